@@ src/wgat_pkg.sv @@
// ----------------------------------------------------------------------------
// wgat_pkg: shared types for the weighted graph adjacency table
// Opcodes, beat payloads, controller states and the command/status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package wgat_pkg;

	localparam int unsigned NODES_DEF = 8;
	localparam int unsigned ID_W      = 3;
	localparam int unsigned VAL_W     = 32;

	localparam logic signed [VAL_W-1:0] VALUE_NONE = -32'sd1;

	typedef enum logic [2:0] {
		OP_ADD_NODE = 3'd0,
		OP_DEL_NODE = 3'd1,
		OP_ADD_EDGE = 3'd2,
		OP_DEL_EDGE = 3'd3,
		OP_QUERY    = 3'd4,
		OP_DEGREE   = 3'd5,
		OP_NBRS     = 3'd6,
		OP_MATRIX   = 3'd7
	} op_t;

	typedef struct packed {
		logic [2:0]              opcode;
		logic [ID_W-1:0]         node_a;
		logic [ID_W-1:0]         node_b;
		logic signed [VAL_W-1:0] edge_weight_in;
	} req_t;

	typedef struct packed {
		logic                    found;
		logic signed [VAL_W-1:0] value;
		logic [ID_W-1:0]         row_index;
		logic [ID_W-1:0]         col_index;
		logic                    last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_QUERY,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		EK_SINGLE,
		EK_QUERY,
		EK_SCAN
	} emit_kind_t;

	typedef struct packed {
		logic       latch;
		logic       rd_query;
		logic       rd_scan;
		logic       scan_clr;
		logic       scan_adv;
		logic       emit;
		emit_kind_t kind;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic empty;
		logic hit;
		logic scan_last;
		logic slot_free;
	} stat_t;

endpackage

@@ src/wgat_stream_if.sv @@
// ----------------------------------------------------------------------------
// wgat_stream_if: valid/ready channel
// Carries one payload beat per cycle when valid and ready are both high.
// ----------------------------------------------------------------------------
interface wgat_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ src/wgat_ctrl.sv @@
// ----------------------------------------------------------------------------
// wgat_ctrl: operation sequencer
// Steps each operation through execute and, as needed, weight read or
// table scan; issues result writes only when the output register has room.
// ----------------------------------------------------------------------------
module wgat_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  wgat_pkg::stat_t   stat,
	output wgat_pkg::cmd_t    cmd,
	output wgat_pkg::state_t  state
);
	import wgat_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (stat.op)
					OP_QUERY: state_d = ST_QUERY;
					OP_NBRS, OP_MATRIX: begin
						if (!stat.empty) begin
							state_d = ST_SCAN;
						end else if (stat.slot_free) begin
							state_d = ST_IDLE;
						end
					end
					default: begin
						if (stat.slot_free) state_d = ST_IDLE;
					end
				endcase
			end
			ST_QUERY: begin
				if (stat.slot_free) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (stat.hit) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.slot_free) state_d = stat.scan_last ? ST_IDLE : ST_SCAN;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.kind  = EK_SINGLE;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.latch = req_valid;
			end
			ST_EXEC: begin
				case (stat.op)
					OP_QUERY: cmd.rd_query = 1'b1;
					OP_NBRS, OP_MATRIX: begin
						if (!stat.empty) begin
							cmd.scan_clr = 1'b1;
						end else begin
							cmd.emit = stat.slot_free;
						end
					end
					default: cmd.emit = stat.slot_free;
				endcase
			end
			ST_QUERY: begin
				cmd.emit = stat.slot_free;
				cmd.kind = EK_QUERY;
			end
			ST_SCAN: begin
				// read the weight for a cell that yields a beat, skip the rest
				cmd.rd_scan  = stat.hit;
				cmd.scan_adv = !stat.hit;
			end
			ST_EMIT: begin
				cmd.emit     = stat.slot_free;
				cmd.kind     = EK_SCAN;
				cmd.scan_adv = stat.slot_free && !stat.scan_last;
			end
			default: begin
				cmd.emit = 1'b0;
			end
		endcase
	end

	assign state = state_q;

endmodule

@@ src/wgat_dp.sv @@
// ----------------------------------------------------------------------------
// wgat_dp: table datapath
// Presence bits, edge rows, weight memory, scan counters, result
// formatting and the output register.
// ----------------------------------------------------------------------------
module wgat_dp #(
	parameter int unsigned NODES = wgat_pkg::NODES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  wgat_pkg::req_t   req_data,
	input  wgat_pkg::cmd_t   cmd,
	output wgat_pkg::stat_t  stat,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output wgat_pkg::rsp_t   rsp_data
);
	import wgat_pkg::*;

	localparam int unsigned IW    = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int unsigned AW    = 2 * IW;
	localparam int unsigned DEPTH = 1 << AW;
	localparam int unsigned DW    = $clog2(NODES + 1);
	localparam logic [ID_W:0]  NodesW  = (ID_W + 1)'(NODES);
	localparam logic [IW-1:0]  LastIdx = IW'(NODES - 1);

	// operation fields
	op_t                     op_q;
	logic [ID_W-1:0]         a_q;
	logic [ID_W-1:0]         b_q;
	logic signed [VAL_W-1:0] w_q;

	// table state
	logic [NODES-1:0]        present_q;
	logic [NODES-1:0]        edge_q [NODES];
	logic signed [VAL_W-1:0] weight_mem [DEPTH];
	logic signed [VAL_W-1:0] rdata_q;

	logic [IW-1:0]           i_q;
	logic [IW-1:0]           j_q;

	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic             a_ok;
	logic             b_ok;
	logic             ab_ok;
	logic [IW-1:0]    a_idx;
	logic [IW-1:0]    b_idx;
	logic [NODES-1:0] a_oh;
	logic [NODES-1:0] b_oh;
	logic [NODES-1:0] row_a;
	logic [NODES-1:0] scan_row;
	logic             pres_a;
	logic             edge_ab;
	logic             cell_edge;
	logic [DW-1:0]    deg;
	logic             later_j_nb;
	logic             later_j_pr;
	logic             later_i;
	logic             slot_free;
	logic             apply;
	logic             mem_we;
	logic [AW-1:0]    rd_addr;
	rsp_t             res;

	assign a_ok    = {1'b0, a_q} < NodesW;
	assign b_ok    = {1'b0, b_q} < NodesW;
	assign ab_ok   = a_ok && b_ok;
	assign a_idx   = a_q[IW-1:0];
	assign b_idx   = b_q[IW-1:0];
	assign a_oh    = {{(NODES-1){1'b0}}, 1'b1} << a_idx;
	assign b_oh    = {{(NODES-1){1'b0}}, 1'b1} << b_idx;
	assign row_a   = a_ok ? edge_q[a_idx] : '0;
	assign pres_a  = a_ok && present_q[a_idx];
	assign edge_ab = ab_ok && row_a[b_idx];

	assign scan_row  = edge_q[i_q];
	assign cell_edge = scan_row[j_q];

	always_comb begin
		deg        = '0;
		later_j_nb = 1'b0;
		later_j_pr = 1'b0;
		later_i    = 1'b0;
		for (int k = 0; k < NODES; k++) begin
			deg = deg + DW'(row_a[k]);
			if (IW'(k) > j_q) begin
				later_j_nb = later_j_nb | row_a[k];
				later_j_pr = later_j_pr | present_q[k];
			end
			if (IW'(k) > i_q) begin
				later_i = later_i | present_q[k];
			end
		end
	end

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign apply     = cmd.emit && (cmd.kind == EK_SINGLE);
	assign mem_we    = apply && (op_q == OP_ADD_EDGE) && ab_ok;
	assign rd_addr   = cmd.rd_scan ? {i_q, j_q} : {a_idx, b_idx};

	always_comb begin
		stat.op        = op_q;
		stat.slot_free = slot_free;
		stat.empty     = 1'b0;
		stat.hit       = 1'b0;
		stat.scan_last = 1'b0;
		case (op_q)
			OP_NBRS: begin
				stat.empty     = !pres_a || (row_a == '0);
				stat.hit       = row_a[j_q];
				stat.scan_last = !later_j_nb;
			end
			OP_MATRIX: begin
				stat.empty     = (present_q == '0);
				stat.hit       = present_q[i_q] && present_q[j_q];
				stat.scan_last = !later_j_pr && !later_i;
			end
			default: begin
				stat.empty = 1'b0;
			end
		endcase
	end

	always_comb begin
		res      = '0;
		res.last = 1'b1;
		case (cmd.kind)
			EK_SINGLE: begin
				case (op_q)
					OP_ADD_NODE: res.found = a_ok;
					OP_DEL_NODE: res.found = pres_a;
					OP_ADD_EDGE: begin
						res.found = ab_ok;
						res.value = ab_ok ? w_q : '0;
					end
					OP_DEL_EDGE: res.found = edge_ab;
					OP_DEGREE: begin
						res.found = pres_a;
						res.value = pres_a ? VAL_W'(deg) : '0;
					end
					default: res.found = 1'b0;
				endcase
			end
			EK_QUERY: begin
				res.found = edge_ab;
				res.value = edge_ab ? rdata_q : VALUE_NONE;
			end
			EK_SCAN: begin
				if (op_q == OP_NBRS) begin
					res.found = 1'b1;
					res.value = VAL_W'(j_q);
					res.last  = !later_j_nb;
				end else begin
					res.found     = cell_edge;
					res.value     = cell_edge ? rdata_q : '0;
					res.row_index = ID_W'(i_q);
					res.col_index = ID_W'(j_q);
					res.last      = !later_j_pr && !later_i;
				end
			end
			default: res.last = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			for (int k = 0; k < NODES; k++) begin
				edge_q[k] <= '0;
			end
		end else if (apply) begin
			case (op_q)
				OP_ADD_NODE: begin
					if (a_ok) present_q <= present_q | a_oh;
				end
				OP_DEL_NODE: begin
					if (a_ok) begin
						present_q <= present_q & ~a_oh;
						// drop the node's row and its column
						for (int k = 0; k < NODES; k++) begin
							if (IW'(k) == a_idx) begin
								edge_q[k] <= '0;
							end else begin
								edge_q[k] <= edge_q[k] & ~a_oh;
							end
						end
					end
				end
				OP_ADD_EDGE: begin
					if (ab_ok) begin
						present_q     <= present_q | a_oh | b_oh;
						edge_q[a_idx] <= edge_q[a_idx] | b_oh;
					end
				end
				OP_DEL_EDGE: begin
					if (ab_ok) edge_q[a_idx] <= edge_q[a_idx] & ~b_oh;
				end
				default: begin
					present_q <= present_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) weight_mem[{a_idx, b_idx}] <= w_q;
		if (cmd.rd_query || cmd.rd_scan) rdata_q <= weight_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= op_t'(req_data.opcode);
			a_q  <= req_data.node_a;
			b_q  <= req_data.node_b;
			w_q  <= req_data.edge_weight_in;
		end
		if (cmd.scan_clr) begin
			i_q <= '0;
			j_q <= '0;
		end else if (cmd.scan_adv) begin
			if (j_q == LastIdx) begin
				j_q <= '0;
				i_q <= i_q + 1'b1;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
		if (cmd.emit) rsp_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

@@ src/weighted_graph_adjacency_table.sv @@
// ----------------------------------------------------------------------------
// weighted_graph_adjacency_table: directed weighted graph table engine
// Holds node presence, edge rows and edge weights over NODES node slots.
//
// Usage: each req beat carries one operation (opcode, node_a, node_b,
// edge_weight_in); each rsp beat carries one result, and the final result
// of an operation has last set. req is taken only between operations.
// Node and edge add/delete and degree are answered from the execute state;
// a query reads the weight there and is answered in the query state.
// After accept and setup, a neighbour list walks the row up to its last
// neighbour and a matrix dump walks the cells up to the last present pair,
// one cell per cycle; each beat produced holds the walk in the emit state
// (the weight memory read port is shared) until the output register frees.
// A finished result waits in the output register while the next req beat
// is taken; when rsp stalls, the sequencer holds until the register frees.
// Reset clears all nodes and edges; the weight memory is not cleared, as
// a weight is only read behind its edge bit. No clearing pass is needed.
// ----------------------------------------------------------------------------
module weighted_graph_adjacency_table #(
	parameter int unsigned NODES = wgat_pkg::NODES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	wgat_stream_if.sink         req,
	wgat_stream_if.source       rsp
);
	import wgat_pkg::*;

	cmd_t   ctl_cmd;
	stat_t  ctl_stat;
	state_t ctl_state;

	wgat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (ctl_stat),
		.cmd       (ctl_cmd),
		.state     (ctl_state)
	);

	wgat_dp #(
		.NODES (NODES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.cmd       (ctl_cmd),
		.stat      (ctl_stat),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data)
	);

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.emit |-> (!rsp.valid || rsp.ready))
		else $error("result written over a beat not yet taken");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready && !rsp.data.last) |->
		(ctl_state == ST_SCAN || ctl_state == ST_EMIT))
		else $error("operation ended before its last beat");

	a_query_read: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_state == ST_QUERY && $past(ctl_state) != ST_QUERY) |->
		$past(ctl_cmd.rd_query))
		else $error("query result without a weight read");
`endif

endmodule

@@ tb/sv/weighted_graph_adjacency_table_tb.sv @@
// ----------------------------------------------------------------------------
// weighted_graph_adjacency_table_tb: self-checking bench for the graph table
// Drives operations on the req channel in random bursts and stalls the rsp
// channel on a changing pattern. A local image of the graph works out every
// result beat of each accepted operation, and each rsp beat is compared
// field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
module weighted_graph_adjacency_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wgat_pkg::*;

	localparam int unsigned SLOTS      = NODES_DEF;
	localparam int unsigned DUMP_BEATS = SLOTS * SLOTS;
	localparam int unsigned MAX_CYCLES = 4_000_000;

	typedef enum int unsigned {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_CHOKE
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	wgat_stream_if #(.T(req_t)) req_if ();
	wgat_stream_if #(.T(rsp_t)) rsp_if ();

	weighted_graph_adjacency_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #6 clk = ~clk;

	// graph image
	bit                      slot_used [SLOTS];
	logic [SLOTS-1:0]        out_edges [SLOTS];
	logic signed [VAL_W-1:0] edge_weight [SLOTS][SLOTS];

	rsp_t        pending_answers [$];
	bit          failed = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	bit          tx_bursty = 1'b0;
	rx_mode_t    rx_mode = RX_FREE;
	logic [15:0] stall_word = '0;
	int unsigned stall_pos = 0;

	function automatic rsp_t make_beat(logic f, logic signed [VAL_W-1:0] v,
			logic [ID_W-1:0] r, logic [ID_W-1:0] c);
		rsp_t beat;
		beat.found     = f;
		beat.value     = v;
		beat.row_index = r;
		beat.col_index = c;
		beat.last      = 1'b0;
		return beat;
	endfunction

	// Update the graph image and queue the result beats of one operation.
	function automatic void apply_graph_op(req_t item);
		rsp_t beats [DUMP_BEATS];
		int   n;
		int   a;
		int   b;
		bit   a_ok;
		bit   b_ok;
		n    = 0;
		a    = int'(item.node_a);
		b    = int'(item.node_b);
		a_ok = a < SLOTS;
		b_ok = b < SLOTS;
		case (op_t'(item.opcode))
			OP_ADD_NODE: begin
				if (a_ok) begin
					slot_used[a] = 1'b1;
					beats[0] = make_beat(1'b1, '0, '0, '0);
					n = 1;
				end
			end
			OP_DEL_NODE: begin
				if (a_ok) begin
					beats[0] = make_beat(slot_used[a], '0, '0, '0);
					n = 1;
					slot_used[a] = 1'b0;
					out_edges[a] = '0;
					for (int i = 0; i < SLOTS; i++)
						out_edges[i][a] = 1'b0;
				end
			end
			OP_ADD_EDGE: begin
				if (a_ok && b_ok) begin
					slot_used[a] = 1'b1;
					slot_used[b] = 1'b1;
					out_edges[a][b] = 1'b1;
					edge_weight[a][b] = item.edge_weight_in;
					beats[0] = make_beat(1'b1, item.edge_weight_in, '0, '0);
					n = 1;
				end
			end
			OP_DEL_EDGE: begin
				if (a_ok && b_ok) begin
					beats[0] = make_beat(out_edges[a][b], '0, '0, '0);
					n = 1;
					out_edges[a][b] = 1'b0;
				end
			end
			OP_QUERY: begin
				if (a_ok && b_ok && out_edges[a][b])
					beats[0] = make_beat(1'b1, edge_weight[a][b], '0, '0);
				else
					beats[0] = make_beat(1'b0, VALUE_NONE, '0, '0);
				n = 1;
			end
			OP_DEGREE: begin
				if (a_ok && slot_used[a]) begin
					beats[0] = make_beat(1'b1, $countones(out_edges[a]), '0, '0);
					n = 1;
				end
			end
			OP_NBRS: begin
				if (a_ok && slot_used[a]) begin
					for (int j = 0; j < SLOTS; j++) begin
						if (out_edges[a][j]) begin
							beats[n] = make_beat(1'b1, j, '0, '0);
							n = n + 1;
						end
					end
				end
			end
			default: begin
				for (int i = 0; i < SLOTS; i++) begin
					for (int j = 0; j < SLOTS; j++) begin
						if (slot_used[i] && slot_used[j]) begin
							if (out_edges[i][j])
								beats[n] = make_beat(1'b1, edge_weight[i][j],
									ID_W'(i), ID_W'(j));
							else
								beats[n] = make_beat(1'b0, '0, ID_W'(i), ID_W'(j));
							n = n + 1;
						end
					end
				end
			end
		endcase
		if (n == 0) begin
			beats[0] = make_beat(1'b0, '0, '0, '0);
			n = 1;
		end
		beats[n-1].last = 1'b1;
		for (int k = 0; k < n; k++)
			pending_answers = {pending_answers, beats[k]};
	endfunction

	function automatic void compare_field(string name, logic [VAL_W-1:0] want,
			logic [VAL_W-1:0] got);
		if (got !== want) begin
			failed = 1'b1;
			$display("%0t: rsp %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	// Send one operation; call at a falling edge, returns at a falling edge.
	task automatic send_op(op_t op, logic [ID_W-1:0] a, logic [ID_W-1:0] b,
			logic signed [VAL_W-1:0] w);
		req_t item;
		item.opcode         = op;
		item.node_a         = a;
		item.node_b         = b;
		item.edge_weight_in = w;
		req_if.data  <= item;
		req_if.valid <= 1'b1;
		@(posedge clk);
		while (req_if.ready !== 1'b1)
			@(posedge clk);
		apply_graph_op(item);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left = burst_left - 1;
		end else if (tx_bursty) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	function automatic logic signed [VAL_W-1:0] random_weight();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return -32'sd1;
			3: return $signed(32'($urandom_range(0, 40))) - 32'sd20;
			default: return $signed($urandom);
		endcase
	endfunction

	// Steer a and b onto an existing edge, if there is one.
	function automatic void pick_live_edge(inout logic [ID_W-1:0] a,
			inout logic [ID_W-1:0] b);
		int unsigned start;
		int unsigned flat;
		start = $urandom_range(0, DUMP_BEATS - 1);
		for (int unsigned k = 0; k < DUMP_BEATS; k++) begin
			flat = (start + k) % DUMP_BEATS;
			if (out_edges[flat / SLOTS][flat % SLOTS]) begin
				a = ID_W'(flat / SLOTS);
				b = ID_W'(flat % SLOTS);
				return;
			end
		end
	endfunction

	task automatic test_empty_graph();
		send_op(OP_MATRIX, 3'd0, 3'd0, '0);
		send_op(OP_NBRS, 3'd3, 3'd5, '0);
		send_op(OP_DEGREE, 3'd0, 3'd7, '0);
		send_op(OP_QUERY, 3'd7, 3'd0, '0);
		send_op(OP_DEL_NODE, 3'd5, 3'd2, 32'sh7FFF_FFFF);
		send_op(OP_DEL_EDGE, 3'd1, 3'd2, '0);
	endtask

	task automatic test_node_ops();
		send_op(OP_ADD_NODE, 3'd0, 3'd7, -32'sd1);
		send_op(OP_ADD_NODE, 3'd7, 3'd0, '0);
		send_op(OP_DEGREE, 3'd7, 3'd0, '0);
		send_op(OP_NBRS, 3'd7, 3'd0, '0);
		send_op(OP_MATRIX, 3'd7, 3'd7, '0);
	endtask

	task automatic test_edge_ops();
		send_op(OP_ADD_EDGE, 3'd0, 3'd7, 32'sh7FFF_FFFF);
		send_op(OP_ADD_EDGE, 3'd7, 3'd0, 32'sh8000_0000);
		// self loop also creates node 3
		send_op(OP_ADD_EDGE, 3'd3, 3'd3, -32'sd1);
		send_op(OP_ADD_EDGE, 3'd0, 3'd3, 32'sh5A5A_A5A5);
		send_op(OP_ADD_EDGE, 3'd0, 3'd7, '0);
		send_op(OP_QUERY, 3'd0, 3'd7, '0);
		send_op(OP_QUERY, 3'd7, 3'd0, '0);
		send_op(OP_DEGREE, 3'd0, 3'd0, '0);
		send_op(OP_NBRS, 3'd0, 3'd0, '0);
	endtask

	task automatic test_deletions();
		send_op(OP_DEL_EDGE, 3'd0, 3'd3, '0);
		send_op(OP_DEL_EDGE, 3'd0, 3'd3, '0);
		// drop node 7 with both its row and its column
		send_op(OP_DEL_NODE, 3'd7, 3'd0, '0);
		send_op(OP_QUERY, 3'd0, 3'd7, '0);
		send_op(OP_MATRIX, 3'd0, 3'd0, '0);
	endtask

	task automatic test_random_traffic(int unsigned items);
		int unsigned     pick;
		logic [ID_W-1:0] a;
		logic [ID_W-1:0] b;
		for (int unsigned k = 0; k < items; k++) begin
			if (k % 60 == 0) begin
				tx_bursty = 1'($urandom_range(0, 1));
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
			end
			a    = ID_W'($urandom_range(0, SLOTS - 1));
			b    = ID_W'($urandom_range(0, SLOTS - 1));
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_op(OP_ADD_NODE, a, b, random_weight());
			end else if (pick < 14) begin
				send_op(OP_DEL_NODE, a, b, random_weight());
			end else if (pick < 42) begin
				send_op(OP_ADD_EDGE, a, b, random_weight());
			end else if (pick < 50) begin
				if ($urandom_range(0, 2) != 0)
					pick_live_edge(a, b);
				send_op(OP_DEL_EDGE, a, b, random_weight());
			end else if (pick < 66) begin
				if ($urandom_range(0, 2) != 0)
					pick_live_edge(a, b);
				send_op(OP_QUERY, a, b, random_weight());
			end else if (pick < 74) begin
				send_op(OP_DEGREE, a, b, random_weight());
			end else if (pick < 86) begin
				send_op(OP_NBRS, a, b, random_weight());
			end else if (pick < 94) begin
				send_op(OP_MATRIX, a, b, random_weight());
			end else if (pick < 96) begin
				// tear the whole graph down, then dump it
				for (int n = 0; n < SLOTS; n++)
					send_op(OP_DEL_NODE, ID_W'(n), b, random_weight());
				send_op(OP_MATRIX, a, b, random_weight());
			end else begin
				for (int n = 0; n < 6; n++)
					send_op(OP_ADD_EDGE, ID_W'($urandom_range(0, SLOTS - 1)),
						ID_W'($urandom_range(0, SLOTS - 1)), random_weight());
				send_op(OP_NBRS, a, b, random_weight());
			end
		end
	endtask

	// rsp stall pattern, reloaded after its 16 bits are used
	always @(negedge clk) begin
		rsp_if.ready <= ~stall_word[stall_pos];
		stall_pos = stall_pos + 1;
		if (stall_pos == 16) begin
			stall_pos = 0;
			case (rx_mode)
				RX_FREE:  stall_word = '0;
				RX_LIGHT: stall_word = 16'($urandom & $urandom);
				RX_HEAVY: stall_word = 16'($urandom | $urandom);
				default:  stall_word = 16'hFFFE;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_answers.size() == 0) begin
				failed = 1'b1;
				$display("%0t: rsp beat with nothing outstanding, expected none actual %h",
					$time, rsp_if.data);
			end else begin
				rsp_t want;
				want = pending_answers.pop_front();
				compare_field("found", VAL_W'(want.found), VAL_W'(rsp_if.data.found));
				compare_field("value", want.value, rsp_if.data.value);
				compare_field("row_index", VAL_W'(want.row_index),
					VAL_W'(rsp_if.data.row_index));
				compare_field("col_index", VAL_W'(want.col_index),
					VAL_W'(rsp_if.data.col_index));
				compare_field("last", VAL_W'(want.last), VAL_W'(rsp_if.data.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == MAX_CYCLES) begin
			$display("weighted_graph_adjacency_table test failed");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			out_edges[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_bursty = 1'b1;
		rx_mode   = RX_LIGHT;
		test_empty_graph();
		test_node_ops();
		test_edge_ops();
		test_deletions();
		test_random_traffic(230);

		req_if.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (!failed)
			$display("weighted_graph_adjacency_table test passed");
		else
			$display("weighted_graph_adjacency_table test failed");
		$finish;
	end

endmodule
